>>> rtl/efmt_pkg.sv
// Shared types and constants for the encoder frame multiturn tracker.
package efmt_pkg;

    // Frame layout
    localparam int FRAME_BYTES = 6;
    localparam int BCNT_W      = 3;
    localparam int POS_W       = 24;
    localparam int TURN_W      = 32;
    localparam int TOTAL_W     = 56;
    localparam int CNT_W       = 32;
    localparam int BITS_W      = 5;

    // Input commands
    localparam logic [1:0] CMD_BYTE     = 2'd0;
    localparam logic [1:0] CMD_IDLE     = 2'd1;
    localparam logic [1:0] CMD_LINE_ERR = 2'd2;

    // Frame status codes
    localparam logic [2:0] FS_OK       = 3'd0;
    localparam logic [2:0] FS_BAD_LEN  = 3'd1;
    localparam logic [2:0] FS_BAD_ID   = 3'd2;
    localparam logic [2:0] FS_BAD_SUM  = 3'd3;
    localparam logic [2:0] FS_LINE_ERR = 3'd4;

    // Configuration register indexes and reset values
    localparam int         CFG_IDX_W      = 1;
    localparam int         CFG_DATA_W     = 8;
    localparam logic [0:0] REG_POS_BITS   = 1'd0;
    localparam logic [0:0] REG_FRAME_ID   = 1'd1;
    localparam logic [4:0] POS_BITS_RESET = 5'd17;
    localparam logic [4:0] POS_BITS_MAX   = 5'd24;
    localparam logic [7:0] FRAME_ID_RESET = 8'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]                frame_status;
        logic                      online;
        logic                      checksum_good;
        logic [7:0]                status_byte;
        logic [1:0]                encoder_error_bits;
        logic [1:0]                comm_alarm_bits;
        logic [POS_W-1:0]          position_raw;
        logic signed [TURN_W-1:0]  turns;
        logic signed [TOTAL_W-1:0] total_counts;
        logic [CNT_W-1:0]          good_frames;
        logic [CNT_W-1:0]          bad_frames;
    } out_item_t;

    // Frame check result handed from the frame receiver to the tracker
    typedef struct packed {
        logic [2:0]       code;
        logic [7:0]       status;
        logic [POS_W-1:0] position;
    } frame_chk_t;

endpackage

>>> rtl/efmt_frame_rx.sv
// Frame byte collection, length/id/checksum check and position unpacking.
module efmt_frame_rx (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       byte_we,
    input  logic                       frame_end,
    input  logic [7:0]                 rx_byte,
    input  logic [efmt_pkg::BITS_W-1:0] pos_bits,
    input  logic [7:0]                 frame_id,
    output efmt_pkg::frame_chk_t       chk
);
    import efmt_pkg::*;

    localparam logic [BCNT_W-1:0] CNT_FULL = BCNT_W'(FRAME_BYTES);
    localparam logic [BCNT_W-1:0] CNT_SUM  = BCNT_W'(FRAME_BYTES - 1);
    localparam logic [BCNT_W-1:0] CNT_SAT  = {BCNT_W{1'b1}};

    logic [7:0]        frame_reg [FRAME_BYTES];
    logic [BCNT_W-1:0] cnt_reg;
    logic [7:0]        xor_reg;
    logic [POS_W-1:0]  pos_mask;

    // Count bytes of the current frame, saturating on overlong frames
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (frame_end) begin
            cnt_reg <= '0;
        end else if (byte_we && cnt_reg != CNT_SAT) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Store frame bytes and accumulate the XOR of the covered bytes
    always_ff @(posedge aclk) begin
        if (byte_we && cnt_reg < CNT_FULL) begin
            frame_reg[cnt_reg] <= rx_byte;
        end
        if (byte_we) begin
            if (cnt_reg == '0) begin
                xor_reg <= rx_byte;
            end else if (cnt_reg < CNT_SUM) begin
                xor_reg <= xor_reg ^ rx_byte;
            end
        end
    end

    // Check the frame and unpack the little-endian position
    always_comb begin
        pos_mask     = {POS_W{1'b1}} >> (POS_BITS_MAX - pos_bits);
        chk.status   = frame_reg[1];
        chk.position = {frame_reg[4], frame_reg[3], frame_reg[2]} & pos_mask;
        if (cnt_reg != CNT_FULL) begin
            chk.code = FS_BAD_LEN;
        end else if (frame_reg[0] != frame_id) begin
            chk.code = FS_BAD_ID;
        end else if (xor_reg != frame_reg[FRAME_BYTES-1]) begin
            chk.code = FS_BAD_SUM;
        end else begin
            chk.code = FS_OK;
        end
    end

endmodule

>>> rtl/encoder_frame_multiturn_tracker_unit.sv
// Encoder reply frame receiver with turn tracking: top level.
// Takes one item per clock unless back-pressure holds a result: a received
// byte, an idle-line frame end or a line error. A frame end or line error
// yields one result: the event updates the tracking state at its transfer,
// and the result register is loaded from that state on the next cycle (or
// later under back-pressure), so sustained throughput is one item per cycle.
// Bytes and unused command code 3 give no result. The result carries the
// frame status, link flags, held status byte and position, the turn count,
// the combined count turns * 2^bits + position, and good/bad frame counters.
// Configuration (resolution bits, expected id byte) is written through a
// plain write port, only while the block is idle: a user duty, not enforced.
module encoder_frame_multiturn_tracker_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  efmt_pkg::in_item_t                s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output efmt_pkg::out_item_t               m_item,
    input  logic                              cfg_we,
    input  logic [efmt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [efmt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import efmt_pkg::*;

    // Configuration
    logic [BITS_W-1:0] pos_bits_reg;
    logic [7:0]        frame_id_reg;
    logic [BITS_W-1:0] eff_bits;

    // Tracking state
    logic              angle_seen_reg, angle_seen_next;
    logic [POS_W-1:0]  prev_pos_reg, prev_pos_next;
    logic [TURN_W-1:0] turn_reg, turn_next;
    logic [POS_W-1:0]  hpos_reg, hpos_next;
    logic [7:0]        hstatus_reg, hstatus_next;
    logic              online_reg, online_next;
    logic              sum_good_reg, sum_good_next;
    logic [CNT_W-1:0]  good_reg, good_next;
    logic [CNT_W-1:0]  bad_reg, bad_next;

    // Handshake and pending result
    logic              pend_reg, pend_next;
    logic [2:0]        pend_code_reg, pend_code_next;
    logic              m_valid_reg;
    out_item_t         m_item_reg;
    logic              out_free;
    logic              load_out;
    logic              acc;
    logic              byte_we;
    logic              frame_end;

    // Turn arithmetic
    frame_chk_t               chk;
    logic signed [POS_W:0]    diff;
    logic signed [POS_W:0]    half;
    logic signed [POS_W:0]    neg_half;
    logic [TOTAL_W-1:0]       turns_ext;
    logic [TOTAL_W-1:0]       total;

    // Clamp resolution to the supported range
    always_comb begin
        if (pos_bits_reg == '0) begin
            eff_bits = BITS_W'(1);
        end else if (pos_bits_reg > POS_BITS_MAX) begin
            eff_bits = POS_BITS_MAX;
        end else begin
            eff_bits = pos_bits_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_bits_reg <= POS_BITS_RESET;
            frame_id_reg <= FRAME_ID_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_POS_BITS: pos_bits_reg <= cfg_wdata[BITS_W-1:0];
                REG_FRAME_ID: frame_id_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // Handshake: accept while the pending slot is free or drains this cycle
    assign out_free  = !m_valid_reg || m_ready;
    assign load_out  = pend_reg && out_free;
    assign s_ready   = !pend_reg || out_free;
    assign acc       = s_valid && s_ready;
    assign byte_we   = acc && (s_item.cmd == CMD_BYTE);
    assign frame_end = acc && (s_item.cmd == CMD_IDLE || s_item.cmd == CMD_LINE_ERR);

    efmt_frame_rx u_frame_rx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_we   (byte_we),
        .frame_end (frame_end),
        .rx_byte   (s_item.rx_byte),
        .pos_bits  (eff_bits),
        .frame_id  (frame_id_reg),
        .chk       (chk)
    );

    // Position jump against half a revolution
    assign diff     = $signed({1'b0, chk.position}) - $signed({1'b0, prev_pos_reg});
    assign half     = $signed((POS_W+1)'(1) << (eff_bits - 1'b1));
    assign neg_half = -half;

    // Update tracking state on a frame end or line error
    always_comb begin
        angle_seen_next = angle_seen_reg;
        prev_pos_next   = prev_pos_reg;
        turn_next       = turn_reg;
        hpos_next       = hpos_reg;
        hstatus_next    = hstatus_reg;
        online_next     = online_reg;
        sum_good_next   = sum_good_reg;
        good_next       = good_reg;
        bad_next        = bad_reg;
        pend_code_next  = pend_code_reg;
        if (frame_end && s_item.cmd == CMD_LINE_ERR) begin
            bad_next       = bad_reg + 1'b1;
            online_next    = 1'b0;
            pend_code_next = FS_LINE_ERR;
        end else if (frame_end) begin
            pend_code_next = chk.code;
            case (chk.code)
                FS_OK: begin
                    hstatus_next  = chk.status;
                    hpos_next     = chk.position;
                    online_next   = 1'b1;
                    sum_good_next = 1'b1;
                    prev_pos_next = chk.position;
                    good_next     = good_reg + 1'b1;
                    if (!angle_seen_reg) begin
                        turn_next       = '0;
                        angle_seen_next = 1'b1;
                    end else if (diff < neg_half) begin
                        turn_next = turn_reg + 1'b1;
                    end else if (diff > half) begin
                        turn_next = turn_reg - 1'b1;
                    end
                end
                FS_BAD_SUM: begin
                    bad_next      = bad_reg + 1'b1;
                    online_next   = 1'b0;
                    sum_good_next = 1'b0;
                end
                default: begin
                    bad_next    = bad_reg + 1'b1;
                    online_next = 1'b0;
                end
            endcase
        end
    end

    // Hold a pending result until the output register takes it
    always_comb begin
        if (frame_end) begin
            pend_next = 1'b1;
        end else if (load_out) begin
            pend_next = 1'b0;
        end else begin
            pend_next = pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_seen_reg <= 1'b0;
            prev_pos_reg   <= '0;
            turn_reg       <= '0;
            hpos_reg       <= '0;
            hstatus_reg    <= '0;
            online_reg     <= 1'b0;
            sum_good_reg   <= 1'b0;
            good_reg       <= '0;
            bad_reg        <= '0;
            pend_reg       <= 1'b0;
        end else begin
            angle_seen_reg <= angle_seen_next;
            prev_pos_reg   <= prev_pos_next;
            turn_reg       <= turn_next;
            hpos_reg       <= hpos_next;
            hstatus_reg    <= hstatus_next;
            online_reg     <= online_next;
            sum_good_reg   <= sum_good_next;
            good_reg       <= good_next;
            bad_reg        <= bad_next;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_code_reg <= pend_code_next;
    end

    // Combine turns and position into the total count
    assign turns_ext = {{(TOTAL_W-TURN_W){turn_reg[TURN_W-1]}}, turn_reg};
    assign total     = (turns_ext << eff_bits) + {{(TOTAL_W-POS_W){1'b0}}, hpos_reg};

    // Output register: load from held state, drop valid once transferred
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_item_reg.frame_status       <= pend_code_reg;
            m_item_reg.online             <= online_reg;
            m_item_reg.checksum_good      <= sum_good_reg;
            m_item_reg.status_byte        <= hstatus_reg;
            m_item_reg.encoder_error_bits <= hstatus_reg[5:4];
            m_item_reg.comm_alarm_bits    <= hstatus_reg[7:6];
            m_item_reg.position_raw       <= hpos_reg;
            m_item_reg.turns              <= $signed(turn_reg);
            m_item_reg.total_counts       <= $signed(total);
            m_item_reg.good_frames        <= good_reg;
            m_item_reg.bad_frames         <= bad_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

>>> rtl/efmt_checker.sv
// Port-level checks for the encoder frame multiturn tracker, bound to the top.
module efmt_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input efmt_pkg::out_item_t m_item
);
    import efmt_pkg::*;

    // No result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // An accepted frame sets both link flags
    a_ok_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.frame_status == FS_OK) |-> (m_item.online && m_item.checksum_good))
        else $error("good frame without link flags");

    // Any failure leaves the link offline; checksum failure clears its flag
    a_fail_offline: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.frame_status != FS_OK) |->
            (!m_item.online &&
             (m_item.frame_status != FS_BAD_SUM || !m_item.checksum_good)))
        else $error("failed frame left link flags set");

    // Status code stays in range and alarm fields follow the status byte
    a_status_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.frame_status <= FS_LINE_ERR &&
                     m_item.encoder_error_bits == m_item.status_byte[5:4] &&
                     m_item.comm_alarm_bits == m_item.status_byte[7:6]))
        else $error("result status fields inconsistent");

    // A stalled result keeps its counters
    a_hold_counters: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item.good_frames) &&
                                   $stable(m_item.bad_frames)))
        else $error("stalled result changed");

endmodule

bind encoder_frame_multiturn_tracker_unit efmt_checker u_efmt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
